// ----- src/dpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dpm_pkg: shared types and constants
// Field widths, register indexes, reset values and the remainder step used
// by the depth pixel to map point pipeline.
// ----------------------------------------------------------------------------
package dpm_pkg;

  // Fixed internal widths, sized for the widest coordinate and depth
  localparam int DEPTH_MAX_W = 24;  // widest depth sample
  localparam int DIFF_W      = 21;  // signed (col*16 - cx) in Q.4
  localparam int DIFF_MAG_W  = 20;  // magnitude of the above
  localparam int MAG_W       = 44;  // |diff| * depth
  localparam int LO_W        = 30;  // low split of MAG_W
  localparam int HI_W        = MAG_W - LO_W;
  localparam int RECIP_W     = 32;  // 1/f, Q0.32
  localparam int CAM_W       = 48;  // camera coordinate, Q.6 mm, signed
  localparam int ROT_W       = 16;  // rotation entry, Q1.14
  localparam int TRANS_W     = 21;  // translation component, mm
  localparam int ACC_W       = 64;  // map sum, Q.20 mm
  localparam int MM_W        = 32;  // output coordinate
  localparam int ROUND_M_W   = ACC_W - 20;

  localparam logic [7:0] COLOUR_WHITE = 8'hFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RECIP_FOCAL     = 3'd0,
    REG_PRINCIPAL_POINT = 3'd1,
    REG_DEPTH_WINDOW    = 3'd2,
    REG_SAMPLING_MODE   = 3'd3,
    REG_ROTATION_ROW_X  = 3'd4,
    REG_ROTATION_ROW_Y  = 3'd5,
    REG_ROTATION_ROW_Z  = 3'd6,
    REG_TRANSLATION     = 3'd7
  } cfg_reg_t;

  localparam logic [4:0]         SAMPLING_RESET = 5'd17;
  localparam logic [3*ROT_W-1:0] ROT_X_RESET    = 48'h0000_0000_4000;
  localparam logic [3*ROT_W-1:0] ROT_Y_RESET    = 48'h0000_4000_0000;
  localparam logic [3*ROT_W-1:0] ROT_Z_RESET    = 48'h4000_0000_0000;

  // Beat tag travelling beside the arithmetic
  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tag_t;

  // One bit of a restoring remainder: rem < divisor on entry and exit
  function automatic logic [3:0] rem_step(input logic [3:0] rem, input logic b,
                                          input logic [3:0] divisor);
    logic [4:0] t;
    t = {rem, b};
    if (t >= {1'b0, divisor}) t = t - {1'b0, divisor};
    return t[3:0];
  endfunction

endpackage

// ----- src/dpm_screen.sv -----
// ----------------------------------------------------------------------------
// dpm_screen: pixel screening, two stages
// Grid test by bit-serial remainder split over two stages, depth window and
// focal checks, colour choice and the signed offsets from the principal point.
// ----------------------------------------------------------------------------
module dpm_screen import dpm_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COORD_BITS-1:0]  pixel_row,
  input  logic [COORD_BITS-1:0]  pixel_col,
  input  logic [DEPTH_BITS-1:0]  depth_mm,
  input  logic [7:0]             red_in,
  input  logic [7:0]             green_in,
  input  logic [7:0]             blue_in,
  input  logic [3:0]             step_code,
  input  logic                   keep_colour,
  input  logic [15:0]            depth_min,
  input  logic [15:0]            depth_max,
  input  logic [15:0]            cx,
  input  logic [15:0]            cy,
  input  logic                   recip_ok,
  output tag_t                   tag,
  output logic [DEPTH_BITS-1:0]  depth,
  output logic                   neg_x,
  output logic [DIFF_MAG_W-1:0]  mag_x,
  output logic                   neg_y,
  output logic [DIFF_MAG_W-1:0]  mag_y
);

  localparam int HI_BITS = (COORD_BITS + 1) / 2;
  localparam int LO_BITS = COORD_BITS - HI_BITS;

  logic [3:0]            step_eff;
  logic [3:0]            rem_row_a, rem_col_a, rem_row_b, rem_col_b;
  logic                  window_ok;
  logic [DIFF_W-1:0]     dx, dy;

  // stage 1 registers
  logic                  valid1;
  logic [3:0]            rem_row1, rem_col1;
  logic [LO_BITS-1:0]    row_lo1, col_lo1;
  logic [DEPTH_BITS-1:0] depth1;
  logic                  neg_x1, neg_y1;
  logic [DIFF_MAG_W-1:0] mag_x1, mag_y1;
  logic [7:0]            red1, green1, blue1;

  assign step_eff = (step_code == 4'd0) ? 4'd1 : step_code;

  // upper half of the remainder
  always_comb begin
    rem_row_a = '0;
    rem_col_a = '0;
    for (int i = COORD_BITS - 1; i >= LO_BITS; i--) begin
      rem_row_a = rem_step(rem_row_a, pixel_row[i], step_eff);
      rem_col_a = rem_step(rem_col_a, pixel_col[i], step_eff);
    end
  end

  assign window_ok = (DEPTH_MAX_W'(depth_mm) >= DEPTH_MAX_W'(depth_min)) &&
                     (DEPTH_MAX_W'(depth_mm) <= DEPTH_MAX_W'(depth_max));

  assign dx = DIFF_W'({pixel_col, 4'b0000}) - DIFF_W'(cx);
  assign dy = DIFF_W'({pixel_row, 4'b0000}) - DIFF_W'(cy);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= start && window_ok;
    end
  end

  always_ff @(posedge clk) begin
    rem_row1 <= rem_row_a;
    rem_col1 <= rem_col_a;
    row_lo1  <= pixel_row[LO_BITS-1:0];
    col_lo1  <= pixel_col[LO_BITS-1:0];
    depth1   <= depth_mm;
    neg_x1   <= dx[DIFF_W-1];
    neg_y1   <= dy[DIFF_W-1];
    mag_x1   <= dx[DIFF_W-1] ? DIFF_MAG_W'(-dx) : DIFF_MAG_W'(dx);
    mag_y1   <= dy[DIFF_W-1] ? DIFF_MAG_W'(-dy) : DIFF_MAG_W'(dy);
    red1     <= keep_colour ? red_in   : COLOUR_WHITE;
    green1   <= keep_colour ? green_in : COLOUR_WHITE;
    blue1    <= keep_colour ? blue_in  : COLOUR_WHITE;
  end

  // lower half of the remainder
  always_comb begin
    rem_row_b = rem_row1;
    rem_col_b = rem_col1;
    for (int i = LO_BITS - 1; i >= 0; i--) begin
      rem_row_b = rem_step(rem_row_b, row_lo1[i], step_eff);
      rem_col_b = rem_step(rem_col_b, col_lo1[i], step_eff);
    end
  end

  // only the valid bit is reset; the rest is data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= valid1 && (rem_row_b == 4'd0) && (rem_col_b == 4'd0) && recip_ok;
    end
    tag.red   <= red1;
    tag.green <= green1;
    tag.blue  <= blue1;
    depth     <= depth1;
    neg_x     <= neg_x1;
    neg_y     <= neg_y1;
    mag_x     <= mag_x1;
    mag_y     <= mag_y1;
  end

endmodule

// ----- src/dpm_cam.sv -----
// ----------------------------------------------------------------------------
// dpm_cam: one camera axis, three stages
// |offset| * depth, split product with 1/f, round half away to Q.6 mm.
// ----------------------------------------------------------------------------
module dpm_cam import dpm_pkg::*; (
  input  logic                     clk,
  input  logic                     neg,
  input  logic [DIFF_MAG_W-1:0]    diff_mag,
  input  logic [DEPTH_MAX_W-1:0]   depth,
  input  logic [RECIP_W-1:0]       recip,
  output logic signed [CAM_W-1:0]  cam
);

  logic                       neg1, neg2;
  logic [MAG_W-1:0]           mag1;
  logic [HI_W+RECIP_W-1:0]    p_hi2;
  logic [LO_W+RECIP_W-1:0]    p_lo2;
  logic [LO_W+RECIP_W:0]      rnd;
  logic [CAM_W-2:0]           r;

  always_ff @(posedge clk) begin
    neg1  <= neg;
    mag1  <= MAG_W'(diff_mag) * MAG_W'(depth);
    neg2  <= neg1;
    p_hi2 <= (HI_W+RECIP_W)'(mag1[MAG_W-1:LO_W]) * (HI_W+RECIP_W)'(recip);
    p_lo2 <= (LO_W+RECIP_W)'(mag1[LO_W-1:0]) * (LO_W+RECIP_W)'(recip);
  end

  assign rnd = (LO_W+RECIP_W+1)'(p_lo2) + (LO_W+RECIP_W+1)'(1 << (LO_W - 1));
  assign r   = (CAM_W-1)'(p_hi2) + (CAM_W-1)'(rnd >> LO_W);

  always_ff @(posedge clk) begin
    cam <= neg2 ? -$signed({1'b0, r}) : $signed({1'b0, r});
  end

endmodule

// ----- src/dpm_xform.sv -----
// ----------------------------------------------------------------------------
// dpm_xform: one map axis, four stages
// Rotation row dot product, translation, rounding to mm, saturation.
// ----------------------------------------------------------------------------
module dpm_xform import dpm_pkg::*; (
  input  logic                     clk,
  input  logic signed [CAM_W-1:0]  cam_x,
  input  logic signed [CAM_W-1:0]  cam_y,
  input  logic signed [CAM_W-1:0]  cam_z,
  input  logic [3*ROT_W-1:0]       rot_row,
  input  logic [TRANS_W-1:0]       trans,
  output logic [MM_W-1:0]          value
);

  localparam logic [ROUND_M_W-1:0] POS_LIM = 44'h000_7FFF_FFFF;
  localparam logic [ROUND_M_W-1:0] NEG_LIM = 44'h000_8000_0000;

  logic signed [ROT_W-1:0]   r0, r1, r2;
  logic signed [TRANS_W-1:0] t_s;
  logic signed [ACC_W-1:0]   p0, p1, p2, acc;
  logic [ACC_W-1:0]          acc_mag;
  logic                      neg3;
  logic [ROUND_M_W-1:0]      m3;

  assign r0  = rot_row[ROT_W-1:0];
  assign r1  = rot_row[2*ROT_W-1:ROT_W];
  assign r2  = rot_row[3*ROT_W-1:2*ROT_W];
  assign t_s = trans;

  always_ff @(posedge clk) begin
    p0  <= ACC_W'(r0) * ACC_W'(cam_x);
    p1  <= ACC_W'(r1) * ACC_W'(cam_y);
    p2  <= ACC_W'(r2) * ACC_W'(cam_z);
    acc <= p0 + p1 + p2 + (ACC_W'(t_s) <<< 20);
  end

  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  always_ff @(posedge clk) begin
    neg3 <= acc[ACC_W-1];
    m3   <= ROUND_M_W'((acc_mag + ACC_W'(1 << 19)) >> 20);
    if (neg3) begin
      value <= (m3 > NEG_LIM) ? 32'h8000_0000 : -m3[MM_W-1:0];
    end else begin
      value <= (m3 > POS_LIM) ? 32'h7FFF_FFFF : m3[MM_W-1:0];
    end
  end

endmodule

// ----- src/depth_pixel_to_map_point.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_to_map_point: depth pixel to map point, pinhole back-projection
// Screens each pixel, back-projects it through the camera model, applies the
// rigid transform and emits the map point in millimetres.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock at which start is high; busy is tied low,
// so the block never pushes back. Each kept pixel gives one result beat once
// it has passed the stages below, flagged by a single-cycle result_valid; the
// sink has to take it then, there is no hold-off. Pixels that are off the
// sampling grid, whose depth lies outside the window, or that arrive while
// either 1/f is zero give no beat at all, so beats leave in input order but
// with gaps. The stages are: two screening stages (grid remainder and window
// test), three camera stages (offset times depth, the 1/f product, rounding)
// and four transform stages (rotation products, sum with translation,
// rounding to mm, saturation). Configuration is plain write-only registers,
// to be changed while no pixel is in flight.
// ----------------------------------------------------------------------------
module depth_pixel_to_map_point import dpm_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // pixel beat
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_BITS-1:0]  pixel_row,
  input  logic [COORD_BITS-1:0]  pixel_col,
  input  logic [DEPTH_BITS-1:0]  depth_mm,
  input  logic [7:0]             red_in,
  input  logic [7:0]             green_in,
  input  logic [7:0]             blue_in,
  // configuration
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  // map point beat
  output logic                   result_valid,
  output logic [MM_W-1:0]        map_x_mm,
  output logic [MM_W-1:0]        map_y_mm,
  output logic [MM_W-1:0]        map_z_mm,
  output logic [7:0]             red_out,
  output logic [7:0]             green_out,
  output logic [7:0]             blue_out
);

  localparam int CAM_STAGES   = 3;
  localparam int XFORM_STAGES = 4;
  localparam int TAG_STAGES   = CAM_STAGES + XFORM_STAGES;

  // configuration registers
  logic [63:0]          recip_focal;
  logic [31:0]          principal_point;
  logic [31:0]          depth_window;
  logic [4:0]           sampling_mode;
  logic [3*ROT_W-1:0]   rotation_row_x;
  logic [3*ROT_W-1:0]   rotation_row_y;
  logic [3*ROT_W-1:0]   rotation_row_z;
  logic [3*TRANS_W-1:0] translation;

  logic                  recip_ok;
  tag_t                  scr_tag;
  logic [DEPTH_BITS-1:0] scr_depth;
  logic                  scr_neg_x, scr_neg_y;
  logic [DIFF_MAG_W-1:0] scr_mag_x, scr_mag_y;

  logic signed [CAM_W-1:0] cam_x, cam_y, cam_z;
  logic [DEPTH_MAX_W-1:0]  depth_line [CAM_STAGES];
  tag_t                    tag_line   [TAG_STAGES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      recip_focal     <= '0;
      principal_point <= '0;
      depth_window    <= '0;
      sampling_mode   <= SAMPLING_RESET;
      rotation_row_x  <= ROT_X_RESET;
      rotation_row_y  <= ROT_Y_RESET;
      rotation_row_z  <= ROT_Z_RESET;
      translation     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RECIP_FOCAL:     recip_focal     <= cfg_data;
        REG_PRINCIPAL_POINT: principal_point <= cfg_data[31:0];
        REG_DEPTH_WINDOW:    depth_window    <= cfg_data[31:0];
        REG_SAMPLING_MODE:   sampling_mode   <= cfg_data[4:0];
        REG_ROTATION_ROW_X:  rotation_row_x  <= cfg_data[3*ROT_W-1:0];
        REG_ROTATION_ROW_Y:  rotation_row_y  <= cfg_data[3*ROT_W-1:0];
        REG_ROTATION_ROW_Z:  rotation_row_z  <= cfg_data[3*ROT_W-1:0];
        REG_TRANSLATION:     translation     <= cfg_data[3*TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero reciprocal focal length drops everything
  assign recip_ok = (recip_focal[31:0] != '0) && (recip_focal[63:32] != '0);

  dpm_screen #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_screen (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .depth_mm    (depth_mm),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .step_code   (sampling_mode[3:0]),
    .keep_colour (sampling_mode[4]),
    .depth_min   (depth_window[15:0]),
    .depth_max   (depth_window[31:16]),
    .cx          (principal_point[15:0]),
    .cy          (principal_point[31:16]),
    .recip_ok    (recip_ok),
    .tag         (scr_tag),
    .depth       (scr_depth),
    .neg_x       (scr_neg_x),
    .mag_x       (scr_mag_x),
    .neg_y       (scr_neg_y),
    .mag_y       (scr_mag_y)
  );

  dpm_cam u_cam_x (
    .clk      (clk),
    .neg      (scr_neg_x),
    .diff_mag (scr_mag_x),
    .depth    (DEPTH_MAX_W'(scr_depth)),
    .recip    (recip_focal[31:0]),
    .cam      (cam_x)
  );

  dpm_cam u_cam_y (
    .clk      (clk),
    .neg      (scr_neg_y),
    .diff_mag (scr_mag_y),
    .depth    (DEPTH_MAX_W'(scr_depth)),
    .recip    (recip_focal[63:32]),
    .cam      (cam_y)
  );

  // camera z is the depth itself in Q.6; delay it alongside the x/y units
  always_ff @(posedge clk) begin
    depth_line[0] <= DEPTH_MAX_W'(scr_depth);
    for (int i = 1; i < CAM_STAGES; i++) depth_line[i] <= depth_line[i-1];
  end

  assign cam_z = $signed(CAM_W'({depth_line[CAM_STAGES-1], 6'b000000}));

  dpm_xform u_xform_x (
    .clk     (clk),
    .cam_x   (cam_x),
    .cam_y   (cam_y),
    .cam_z   (cam_z),
    .rot_row (rotation_row_x),
    .trans   (translation[TRANS_W-1:0]),
    .value   (map_x_mm)
  );

  dpm_xform u_xform_y (
    .clk     (clk),
    .cam_x   (cam_x),
    .cam_y   (cam_y),
    .cam_z   (cam_z),
    .rot_row (rotation_row_y),
    .trans   (translation[2*TRANS_W-1:TRANS_W]),
    .value   (map_y_mm)
  );

  dpm_xform u_xform_z (
    .clk     (clk),
    .cam_x   (cam_x),
    .cam_y   (cam_y),
    .cam_z   (cam_z),
    .rot_row (rotation_row_z),
    .trans   (translation[3*TRANS_W-1:2*TRANS_W]),
    .value   (map_z_mm)
  );

  // valid and colour follow the arithmetic stage for stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAG_STAGES; i++) tag_line[i].valid <= 1'b0;
    end else begin
      tag_line[0] <= scr_tag;
      for (int i = 1; i < TAG_STAGES; i++) tag_line[i] <= tag_line[i-1];
    end
  end

  assign result_valid = tag_line[TAG_STAGES-1].valid;
  assign red_out      = tag_line[TAG_STAGES-1].red;
  assign green_out    = tag_line[TAG_STAGES-1].green;
  assign blue_out     = tag_line[TAG_STAGES-1].blue;

endmodule
